### src/tvpd_pkg.sv
// ----------------------------------------------------------------------------
// tvpd_pkg
// Shared constants and types of the thermal video packet deframer.
// ----------------------------------------------------------------------------
package tvpd_pkg;

  // Packet geometry.
  localparam int PACKET_BYTES      = 164;
  localparam int PACKETS_PER_FRAME = 60;
  localparam int ROW_PIXELS        = 80;
  localparam int PAYLOAD_OFFSET    = 4;

  localparam logic [7:0] THRESHOLD_RESET = 8'd10;

  // Input word kinds.
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  // Result event codes.
  localparam logic [1:0] EV_PIXEL    = 2'd0;
  localparam logic [1:0] EV_SEQ_LOSS = 2'd1;
  localparam logic [1:0] EV_SIG_LOSS = 2'd2;
  localparam logic [1:0] EV_TIMEOUT  = 2'd3;

  // Packet disposition codes.
  localparam logic [1:0] DISP_UNDECIDED = 2'd0;
  localparam logic [1:0] DISP_ACCEPT    = 2'd1;
  localparam logic [1:0] DISP_DROP      = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       packet_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [15:0] pixel;
    logic [5:0]  row;
    logic [6:0]  column;
    logic        frame_end;
    logic [31:0] frame_number;
  } result_t;

endpackage

### src/tvpd_in_stage.sv
// ----------------------------------------------------------------------------
// tvpd_in_stage
// Input register: holds one accepted word until the deframer takes it.
// ----------------------------------------------------------------------------
module tvpd_in_stage
  import tvpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     advance,
  output logic     item_valid,
  output in_item_t item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // The register may refill in the same cycle it hands its word on.
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### src/tvpd_deframe.sv
// ----------------------------------------------------------------------------
// tvpd_deframe
// Packet header checks, row tracking and pixel assembly for one word.
// ----------------------------------------------------------------------------
module tvpd_deframe
  import tvpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       fire,
  input  in_item_t   item,
  output logic       res_valid,
  output result_t    res
);

  localparam logic [8:0] PKT_BYTES_C  = 9'(PACKET_BYTES);
  localparam logic [5:0] PPF_C        = 6'(PACKETS_PER_FRAME);
  localparam logic [6:0] ROW_PIX_C    = 7'(ROW_PIXELS);
  localparam logic [6:0] LAST_COL_C   = 7'(ROW_PIXELS - 1);
  localparam logic [7:0] PAY_OFF_C    = 8'(PAYLOAD_OFFSET);
  localparam logic [7:0] HDR_LAST_C   = 8'd3;
  localparam logic [7:0] HDR_ROW_C    = 8'd1;

  logic [7:0]  threshold_r;
  logic [5:0]  expected_r,   expected_nxt;
  logic [7:0]  pos_r,        pos_nxt;
  logic [1:0]  disp_r,       disp_nxt;
  logic        hdr_zero_r,   hdr_zero_nxt;
  logic [7:0]  row_r,        row_nxt;
  logic [7:0]  high_r,       high_nxt;
  logic [7:0]  invalid_r,    invalid_nxt;
  logic [31:0] frames_r,     frames_nxt;

  logic [7:0]  pos;
  logic [8:0]  pos_inc;
  logic [7:0]  k;
  logic [6:0]  col;
  logic [7:0]  invalid_inc;
  logic [5:0]  expected_inc;

  always_comb begin
    pos          = item.packet_start ? 8'd0 : pos_r;
    pos_inc      = {1'b0, pos} + 9'd1;
    k            = pos - PAY_OFF_C;
    col          = k[7:1];
    invalid_inc  = invalid_r + 8'd1;
    expected_inc = expected_r + 6'd1;

    expected_nxt = expected_r;
    pos_nxt      = pos_r;
    disp_nxt     = disp_r;
    hdr_zero_nxt = hdr_zero_r;
    row_nxt      = row_r;
    high_nxt     = high_r;
    invalid_nxt  = invalid_r;
    frames_nxt   = frames_r;

    res_valid     = 1'b0;
    res.event_res = EV_PIXEL;
    res.pixel     = 16'd0;
    res.row       = 6'd0;
    res.column    = 7'd0;
    res.frame_end = 1'b0;

    if (fire) begin
      if (item.kind == KIND_TIMEOUT) begin
        expected_nxt  = 6'd0;
        pos_nxt       = 8'd0;
        disp_nxt      = DISP_UNDECIDED;
        hdr_zero_nxt  = 1'b1;
        res_valid     = 1'b1;
        res.event_res = EV_TIMEOUT;
      end else begin
        if (pos == 8'd0) begin
          disp_nxt     = (item.data[3:0] == 4'hF) ? DISP_DROP : DISP_UNDECIDED;
          hdr_zero_nxt = (item.data == 8'h00);
        end else if (pos <= HDR_LAST_C && disp_r == DISP_UNDECIDED) begin
          if (item.data != 8'h00) begin
            hdr_zero_nxt = 1'b0;
          end
          if (pos == HDR_ROW_C) begin
            row_nxt = item.data;
          end
          // The header verdict is made on its last byte.
          if (pos == HDR_LAST_C) begin
            if (hdr_zero_nxt) begin
              invalid_nxt = invalid_inc;
              disp_nxt    = DISP_DROP;
              if (invalid_inc >= threshold_r) begin
                invalid_nxt   = 8'd0;
                expected_nxt  = 6'd0;
                res_valid     = 1'b1;
                res.event_res = EV_SIG_LOSS;
              end
            end else begin
              invalid_nxt = 8'd0;
              if (expected_r == 6'd0) begin
                // Waiting for row zero: other rows are skipped quietly.
                disp_nxt = (row_r == 8'd0) ? DISP_ACCEPT : DISP_DROP;
              end else if (row_r != {2'b00, expected_r}) begin
                expected_nxt  = 6'd0;
                disp_nxt      = DISP_DROP;
                res_valid     = 1'b1;
                res.event_res = EV_SEQ_LOSS;
              end else begin
                disp_nxt = DISP_ACCEPT;
              end
            end
          end
        end else if (pos >= PAY_OFF_C && disp_r == DISP_ACCEPT) begin
          if (col < ROW_PIX_C) begin
            if (!k[0]) begin
              high_nxt = item.data;
            end else begin
              res_valid  = 1'b1;
              res.pixel  = {high_r, item.data};
              res.row    = row_r[5:0];
              res.column = col;
              if (col == LAST_COL_C) begin
                expected_nxt = expected_inc;
                if (expected_inc == PPF_C) begin
                  frames_nxt    = frames_r + 32'd1;
                  invalid_nxt   = 8'd0;
                  expected_nxt  = 6'd0;
                  res.frame_end = 1'b1;
                end
              end
            end
          end
        end
        // Framing wraps on its own when packet_start is missing.
        pos_nxt = (pos_inc >= PKT_BYTES_C) ? 8'd0 : pos_inc[7:0];
      end
    end

    res.frame_number = frames_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      expected_r  <= 6'd0;
      pos_r       <= 8'd0;
      disp_r      <= DISP_UNDECIDED;
      hdr_zero_r  <= 1'b1;
      row_r       <= 8'd0;
      high_r      <= 8'd0;
      invalid_r   <= 8'd0;
      frames_r    <= 32'd0;
    end else begin
      if (cfg_we) begin
        threshold_r <= cfg_wdata;
      end
      expected_r <= expected_nxt;
      pos_r      <= pos_nxt;
      disp_r     <= disp_nxt;
      hdr_zero_r <= hdr_zero_nxt;
      row_r      <= row_nxt;
      high_r     <= high_nxt;
      invalid_r  <= invalid_nxt;
      frames_r   <= frames_nxt;
    end
  end

endmodule

### src/tvpd_out_reg.sv
// ----------------------------------------------------------------------------
// tvpd_out_reg
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module tvpd_out_reg
  import tvpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  logic    res_valid,
  input  result_t res,
  input  logic    out_ready,
  output logic    out_valid,
  output logic    free,
  output result_t out_res
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load ? res_valid : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

### src/thermal_video_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// thermal_video_packet_deframer_core
// Deframes fixed-size thermal video packets into pixel and event words.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle, continuously, as long as the
// result side keeps up: each word passes through an input register, one step
// of header and pixel logic, and a result register, which loads the result
// once it is free. Only the second byte of each payload pair, header byte 3
// on a sequence or signal loss, and a timeout word make a result; other
// words leave none. When the result register is stalled, one more word is
// held in the input register before in_tready drops.
module thermal_video_packet_deframer_core
  import tvpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,      // signal_loss_threshold
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,       // [7:0] data, [8] packet_start, rest zero
  input  logic        in_tuser,       // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,      // [15:0] pixel, [21:16] row, [28:22] column,
                                      // [60:29] frame_number, rest zero
  output logic [1:0]  out_tuser,      // event_res
  output logic        out_tlast       // frame_end
);

  in_item_t in_item;
  in_item_t s1_item;
  logic     s1_valid;
  logic     free;
  logic     fire;
  logic     res_valid;
  result_t  res;
  result_t  out_res;

  assign in_item.kind         = in_tuser;
  assign in_item.data         = in_tdata[7:0];
  assign in_item.packet_start = in_tdata[8];

  assign fire = s1_valid && free;

  tvpd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (free),
    .item_valid (s1_valid),
    .item       (s1_item)
  );

  tvpd_deframe u_deframe (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (s1_item),
    .res_valid (res_valid),
    .res       (res)
  );

  tvpd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .free      (free),
    .out_res   (out_res)
  );

  assign out_tdata = {3'd0, out_res.frame_number, out_res.column,
                      out_res.row, out_res.pixel};
  assign out_tuser = out_res.event_res;
  assign out_tlast = out_res.frame_end;

  // A frame can only end on a pixel word.
  a_frame_end_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == EV_PIXEL)
    else $error("frame end on a non-pixel word");

  // Event words carry no pixel, row or column.
  a_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != EV_PIXEL |-> out_tdata[28:0] == 29'd0)
    else $error("event word with pixel payload");

  // Pixels stay inside the frame geometry.
  a_pixel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == EV_PIXEL |->
      out_res.row < 6'(PACKETS_PER_FRAME) && out_res.column < 7'(ROW_PIXELS))
    else $error("pixel outside the frame");

  // With both registers full and the sink stalled, no word may enter.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && out_tvalid && !out_tready |-> !in_tready)
    else $error("word accepted while pipeline is full");

endmodule
